### rtl/core/grid_obstacle_inflation_core_macros.svh
// Assertion helpers for the grid obstacle inflation RTL.
`ifndef GRID_OBSTACLE_INFLATION_CORE_MACROS_SVH
`define GRID_OBSTACLE_INFLATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GOI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid obstacle inflation: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid obstacle inflation: next-cycle check failed");

`endif

### rtl/core/goi_pkg.sv
`default_nettype none

package goi_pkg;

   // Field widths of the transaction ports.
   localparam int OPCODE_W     = 1;
   localparam int CELL_COL_W   = 9;
   localparam int CELL_ROW_W   = 9;
   localparam int CELL_VALUE_W = 8;
   localparam int STATUS_W     = 1;

   // Configuration register widths and port geometry.
   localparam int DIM_W      = 10;
   localparam int MARGIN_W   = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Default grid geometry.
   localparam int DEF_MAX_COLS   = 512;
   localparam int DEF_MAX_ROWS   = 512;
   localparam int DEF_MAX_MARGIN = 15;

   // Register values after reset.
   localparam logic [DIM_W-1:0]    RST_MAP_WIDTH  = 10'd512;
   localparam logic [DIM_W-1:0]    RST_MAP_HEIGHT = 10'd512;
   localparam logic [MARGIN_W-1:0] RST_MARGIN     = 4'd3;

   // Cell value that marks an obstacle.
   localparam logic [CELL_VALUE_W-1:0] OBSTACLE_VALUE = 8'd100;

   // Status codes of a query result.
   localparam logic [STATUS_W-1:0] STATUS_INSIDE  = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      REG_MAP_WIDTH  = 2'd0,
      REG_MAP_HEIGHT = 2'd1,
      REG_MARGIN     = 2'd2
   } reg_index_type;

endpackage

`default_nettype wire

### rtl/core/grid_obstacle_inflation_core.sv
`default_nettype none
// Channel        Handshake                    Payload
// request        start / busy                 req_opcode, req_cell_col, req_cell_row,
//                                             req_cell_value
// response       rsp_strobe (one cycle)       rsp_inflated_value, rsp_status
// register port  psel, penable, pwrite,       paddr, pwdata, prdata
//                pready (always high)
//
// A cell write or an off-map query leaves busy low.
// An on-map query holds busy while it reads the center cell and then each cell of
// the clipped window ((2*margin+1) squared cells in open space, 49 at margin 3),
// one read at a time through the single grid memory read port.
// The response strobe rises at the edge at which busy falls; it cannot be stalled.
// Synchronous reset restores the registers and the sequencer; grid contents
// are left untouched and are undefined until written.

`include "grid_obstacle_inflation_core_macros.svh"

module grid_obstacle_inflation_core #(
   parameter int MAX_COLS   = goi_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = goi_pkg::DEF_MAX_ROWS,
   parameter int MAX_MARGIN = goi_pkg::DEF_MAX_MARGIN
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   start,
   output logic                                   busy,
   input  logic [goi_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [goi_pkg::CELL_COL_W-1:0]         req_cell_col,
   input  logic [goi_pkg::CELL_ROW_W-1:0]         req_cell_row,
   input  logic signed [goi_pkg::CELL_VALUE_W-1:0] req_cell_value,
   // Response channel.
   output logic                                   rsp_strobe,
   output logic signed [goi_pkg::CELL_VALUE_W-1:0] rsp_inflated_value,
   output logic [goi_pkg::STATUS_W-1:0]           rsp_status,
   // Register port.
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [goi_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [goi_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [goi_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   import goi_pkg::*;

   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_LAST
   } state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CENTER,
      RD_NEIGH
   } rd_kind_type;

   // Linear grid address of a cell.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] col,
                                                   input logic [DIM_W-1:0] row);
      cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
   endfunction

   // Configuration registers.
   logic [DIM_W-1:0]    map_width_ff;
   logic [DIM_W-1:0]    map_height_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic                csr_write;
   reg_index_type       csr_index;

   // Effective geometry after saturation.
   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    height_eff;
   logic [MARGIN_W-1:0] margin_eff;
   logic [DIM_W-1:0]    margin_ext;

   // Request decode.
   logic                accept;
   logic [DIM_W-1:0]    col_ext;
   logic [DIM_W-1:0]    row_ext;
   logic                on_map;
   logic [DIM_W-1:0]    lo_c;
   logic [DIM_W-1:0]    lo_r;
   logic [DIM_W-1:0]    hi_c_raw;
   logic [DIM_W-1:0]    hi_r_raw;
   logic [DIM_W-1:0]    hi_c;
   logic [DIM_W-1:0]    hi_r;

   // Grid memory.
   logic [CELL_VALUE_W-1:0] grid_mem [CELLS];
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [CELL_VALUE_W-1:0] mem_rdata_ff;

   // Sequencer state.
   state_type               state_ff, state_in;
   rd_kind_type             rd_kind_ff, rd_kind_in;
   logic [DIM_W-1:0]        col_ff, col_in;
   logic [DIM_W-1:0]        row_ff, row_in;
   logic [DIM_W-1:0]        c_lo_ff, c_lo_in;
   logic [DIM_W-1:0]        c_hi_ff, c_hi_in;
   logic [DIM_W-1:0]        r_hi_ff, r_hi_in;
   logic [DIM_W-1:0]        cur_c_ff, cur_c_in;
   logic [DIM_W-1:0]        cur_r_ff, cur_r_in;
   logic [CELL_VALUE_W-1:0] center_ff, center_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [CELL_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // Register port decode; the port never inserts wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= RST_MAP_WIDTH;
         map_height_ff <= RST_MAP_HEIGHT;
         margin_ff     <= RST_MARGIN;
      end else if (csr_write) begin
         case (csr_index)
            REG_MAP_WIDTH:  map_width_ff  <= pwdata[DIM_W-1:0];
            REG_MAP_HEIGHT: map_height_ff <= pwdata[DIM_W-1:0];
            REG_MARGIN:     margin_ff     <= pwdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MAP_WIDTH:  prdata = CSR_DATA_W'(map_width_ff);
         REG_MAP_HEIGHT: prdata = CSR_DATA_W'(map_height_ff);
         REG_MARGIN:     prdata = CSR_DATA_W'(margin_ff);
         default:        prdata = '0;
      endcase
   end

   // Saturate the registers to the grid built into the hardware.
   assign width_eff  = (32'(map_width_ff) > 32'(MAX_COLS)) ? DIM_W'(MAX_COLS) : map_width_ff;
   assign height_eff = (32'(map_height_ff) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : map_height_ff;
   assign margin_eff = (32'(margin_ff) > 32'(MAX_MARGIN)) ?
                       MARGIN_W'(MAX_MARGIN) : margin_ff;
   assign margin_ext = DIM_W'(margin_eff);

   // Request decode and window bounds, clipped to the map.
   assign accept   = start && !busy;
   assign col_ext  = DIM_W'(req_cell_col);
   assign row_ext  = DIM_W'(req_cell_row);
   assign on_map   = (col_ext < width_eff) && (row_ext < height_eff);
   assign lo_c     = (col_ext >= margin_ext) ? col_ext - margin_ext : '0;
   assign lo_r     = (row_ext >= margin_ext) ? row_ext - margin_ext : '0;
   assign hi_c_raw = col_ext + margin_ext;
   assign hi_r_raw = row_ext + margin_ext;
   assign hi_c     = (hi_c_raw > width_eff - DIM_W'(1)) ? width_eff - DIM_W'(1) : hi_c_raw;
   assign hi_r     = (hi_r_raw > height_eff - DIM_W'(1)) ? height_eff - DIM_W'(1) : hi_r_raw;

   // On-map cell writes go straight into the grid in the accepting cycle.
   assign mem_we    = accept && (opcode_type'(req_opcode) == OP_WRITE) && on_map;
   assign mem_waddr = cell_addr(col_ext, row_ext);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= req_cell_value;
      end
      mem_rdata_ff <= grid_mem[rd_addr];
   end

   // Scan sequencer: center read, then one window cell per cycle.
   always_comb begin
      state_in      = state_ff;
      rd_kind_in    = RD_NONE;
      col_in        = col_ff;
      row_in        = row_ff;
      c_lo_in       = c_lo_ff;
      c_hi_in       = c_hi_ff;
      r_hi_in       = r_hi_ff;
      cur_c_in      = cur_c_ff;
      cur_r_in      = cur_r_ff;
      center_in     = center_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = cell_addr(cur_c_ff, cur_r_ff);

      // Consume the read issued in the previous cycle.
      if (rd_kind_ff == RD_CENTER) begin
         center_in = mem_rdata_ff;
      end
      if ((rd_kind_ff == RD_NEIGH) && (mem_rdata_ff == OBSTACLE_VALUE)) begin
         hit_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (opcode_type'(req_opcode) == OP_QUERY)) begin
               if (on_map) begin
                  state_in = ST_CENTER;
                  col_in   = col_ext;
                  row_in   = row_ext;
                  c_lo_in  = lo_c;
                  c_hi_in  = hi_c;
                  r_hi_in  = hi_r;
                  cur_c_in = lo_c;
                  cur_r_in = lo_r;
                  hit_in   = 1'b0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_OUTSIDE;
               end
            end
         end
         ST_CENTER: begin
            rd_addr    = cell_addr(col_ff, row_ff);
            rd_kind_in = RD_CENTER;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            rd_kind_in = RD_NEIGH;
            if (cur_c_ff == c_hi_ff) begin
               cur_c_in = c_lo_ff;
               if (cur_r_ff == r_hi_ff) begin
                  state_in = ST_LAST;
               end else begin
                  cur_r_in = cur_r_ff + DIM_W'(1);
               end
            end else begin
               cur_c_in = cur_c_ff + DIM_W'(1);
            end
         end
         ST_LAST: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = hit_in ? OBSTACLE_VALUE : center_ff;
            rsp_status_in = STATUS_INSIDE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      c_lo_ff       <= c_lo_in;
      c_hi_ff       <= c_hi_in;
      r_hi_ff       <= r_hi_in;
      cur_c_ff      <= cur_c_in;
      cur_r_ff      <= cur_r_in;
      center_ff     <= center_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_kind_ff    <= RD_NONE;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_kind_ff    <= rd_kind_in;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Outputs.
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_inflated_value = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;

   // A response appears only once the scan has finished.
   `GOI_ASSERT_IMPLY(a_rsp_after_scan, clock, reset, rsp_strobe, state_ff == ST_IDLE)
   // An on-map query always starts a scan.
   `GOI_ASSERT_NEXT(a_query_scans, clock, reset,
      accept && (opcode_type'(req_opcode) == OP_QUERY) && on_map, state_ff == ST_CENTER)
   // A cell write never produces a response.
   `GOI_ASSERT_NEXT(a_write_silent, clock, reset,
      accept && (opcode_type'(req_opcode) == OP_WRITE), !rsp_strobe)
   // The scan position stays inside the clipped window.
   `GOI_ASSERT_IMPLY(a_scan_bounds, clock, reset, state_ff == ST_SCAN,
      (cur_c_ff >= c_lo_ff) && (cur_c_ff <= c_hi_ff) && (cur_r_ff <= r_hi_ff))
   // An off-map answer carries a zero value.
   `GOI_ASSERT_IMPLY(a_outside_zero, clock, reset,
      rsp_strobe && (rsp_status == STATUS_OUTSIDE), rsp_inflated_value == '0)

endmodule

`default_nettype wire

### bench/inflation_checker.sv
`default_nettype none

// Watches the request, result and register channels of the inflation core,
// keeps its own copy of the grid and the registers, and compares every result
// transaction with the oldest predicted answer.
module inflation_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [goi_pkg::OPCODE_W-1:0]            req_opcode,
   input  logic [goi_pkg::CELL_COL_W-1:0]          req_cell_col,
   input  logic [goi_pkg::CELL_ROW_W-1:0]          req_cell_row,
   input  logic signed [goi_pkg::CELL_VALUE_W-1:0] req_cell_value,
   input  logic                                    rsp_strobe,
   input  logic signed [goi_pkg::CELL_VALUE_W-1:0] rsp_inflated_value,
   input  logic [goi_pkg::STATUS_W-1:0]            rsp_status,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [goi_pkg::CSR_ADDR_W-1:0]          paddr,
   input  logic [goi_pkg::CSR_DATA_W-1:0]          pwdata,
   input  logic [goi_pkg::CSR_DATA_W-1:0]          prdata,
   input  logic                                    pready,
   output int                                      mismatches,
   output int                                      answers_pending,
   output int                                      answers_checked
);
   import goi_pkg::*;

   localparam int GRID_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;

   // One predicted answer, with the queried cell kept for diagnostics.
   typedef struct packed {
      logic [CELL_COL_W-1:0]          col;
      logic [CELL_ROW_W-1:0]          row;
      logic signed [CELL_VALUE_W-1:0] inflated_value;
      logic [STATUS_W-1:0]            status;
   } inflation_answer_type;

   logic [CELL_VALUE_W-1:0] occupancy [0:GRID_CELLS-1];
   logic [DIM_W-1:0]        width_reg;
   logic [DIM_W-1:0]        height_reg;
   logic [MARGIN_W-1:0]     margin_reg;
   inflation_answer_type    answers_due [$];

   int mismatch_count = 0;
   int due_count      = 0;
   int checked_count  = 0;

   assign mismatches      = mismatch_count;
   assign answers_pending = due_count;
   assign answers_checked = checked_count;

   function automatic int clip(int value, int upper);
      return (value > upper) ? upper : value;
   endfunction

   function automatic bit cell_on_map(int col, int row);
      return (col < clip(int'(width_reg), DEF_MAX_COLS)) &&
             (row < clip(int'(height_reg), DEF_MAX_ROWS));
   endfunction

   // Scan the clipped square around an on-map cell; any obstacle in it wins,
   // otherwise the cell's own value is the answer; an off-map cell answers zero.
   function automatic inflation_answer_type predict_answer(int col, int row);
      int reach;
      int c_lo;
      int c_hi;
      int r_lo;
      int r_hi;
      int r;
      int c;
      inflation_answer_type ans;
      ans.col            = CELL_COL_W'(col);
      ans.row            = CELL_ROW_W'(row);
      ans.inflated_value = '0;
      ans.status         = STATUS_OUTSIDE;
      if (cell_on_map(col, row)) begin
         reach = clip(int'(margin_reg), DEF_MAX_MARGIN);
         c_lo  = (col >= reach) ? col - reach : 0;
         r_lo  = (row >= reach) ? row - reach : 0;
         c_hi  = clip(col + reach, clip(int'(width_reg), DEF_MAX_COLS) - 1);
         r_hi  = clip(row + reach, clip(int'(height_reg), DEF_MAX_ROWS) - 1);
         ans.status         = STATUS_INSIDE;
         ans.inflated_value = occupancy[row * DEF_MAX_COLS + col];
         for (r = r_lo; r <= r_hi; r++) begin
            for (c = c_lo; c <= c_hi; c++) begin
               if (occupancy[r * DEF_MAX_COLS + c] == OBSTACLE_VALUE) begin
                  ans.inflated_value = OBSTACLE_VALUE;
               end
            end
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_readback(input string reg_name, input logic [CSR_DATA_W-1:0] want);
      if (prdata !== want) begin
         report_mismatch($sformatf("%s read back 0x%0h, expected 0x%0h",
                                   reg_name, prdata, want));
      end
   endtask

   always @(posedge clock) begin
      inflation_answer_type want;
      if (reset) begin
         width_reg  = RST_MAP_WIDTH;
         height_reg = RST_MAP_HEIGHT;
         margin_reg = RST_MARGIN;
         answers_due.delete();
      end else begin
         // Register port: writes update the local copy, reads are compared with it.
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[CSR_ADDR_W-1:2])
                  REG_MAP_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
                  REG_MAP_HEIGHT: height_reg = pwdata[DIM_W-1:0];
                  REG_MARGIN:     margin_reg = pwdata[MARGIN_W-1:0];
                  default: ;
               endcase
            end else begin
               case (paddr[CSR_ADDR_W-1:2])
                  REG_MAP_WIDTH:  check_readback("map_width", CSR_DATA_W'(width_reg));
                  REG_MAP_HEIGHT: check_readback("map_height", CSR_DATA_W'(height_reg));
                  REG_MARGIN:     check_readback("margin", CSR_DATA_W'(margin_reg));
                  default: ;
               endcase
            end
         end

         // Result transactions are matched in order against the predictions.
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("result (%0d, status %0d) with no query waiting",
                                         rsp_inflated_value, rsp_status));
            end else begin
               want = answers_due.pop_front();
               checked_count++;
               if (rsp_inflated_value !== want.inflated_value) begin
                  report_mismatch($sformatf("query (%0d,%0d): inflated_value %0d, expected %0d",
                                            want.col, want.row, rsp_inflated_value,
                                            want.inflated_value));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("query (%0d,%0d): status %0d, expected %0d",
                                            want.col, want.row, rsp_status, want.status));
               end
            end
         end

         // Accepted requests: writes update the grid copy, queries add a prediction.
         if (start && !busy) begin
            if (req_opcode == OP_WRITE) begin
               if (cell_on_map(req_cell_col, req_cell_row)) begin
                  occupancy[int'(req_cell_row) * DEF_MAX_COLS + int'(req_cell_col)] =
                     req_cell_value;
               end
            end else begin
               answers_due = {answers_due, predict_answer(req_cell_col, req_cell_row)};
            end
         end
      end
      due_count <= answers_due.size();
   end

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
   import goi_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int ZONE_SPAN     = 8;
   localparam int PHASE_ITEMS   = 48;
   localparam int REG_UNMAPPED  = 3;
   localparam int GRID_CELLS    = DEF_MAX_COLS * DEF_MAX_ROWS;
   localparam int COORD_MAX     = (1 << CELL_COL_W) - 1;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [OPCODE_W-1:0]            req_opcode;
   logic [CELL_COL_W-1:0]          req_cell_col;
   logic [CELL_ROW_W-1:0]          req_cell_row;
   logic signed [CELL_VALUE_W-1:0] req_cell_value;
   logic                           rsp_strobe;
   logic signed [CELL_VALUE_W-1:0] rsp_inflated_value;
   logic [STATUS_W-1:0]            rsp_status;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [CSR_ADDR_W-1:0]          paddr;
   logic [CSR_DATA_W-1:0]          pwdata;
   logic [CSR_DATA_W-1:0]          prdata;
   logic                           pready;

   int checker_errors;
   int results_pending;
   int results_compared;

   // Stimulus bookkeeping: which cells hold a value, and the register settings.
   bit               cell_written [0:GRID_CELLS-1];
   logic [DIM_W-1:0]    shadow_width  = RST_MAP_WIDTH;
   logic [DIM_W-1:0]    shadow_height = RST_MAP_HEIGHT;
   logic [MARGIN_W-1:0] shadow_margin = RST_MARGIN;
   bit burst_mode      = 1'b0;
   int cycle_count     = 0;
   int items_sent      = 0;
   int fill_writes     = 0;
   int inside_queries  = 0;
   int outside_queries = 0;
   int settings_used   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_obstacle_inflation_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_cell_col       (req_cell_col),
      .req_cell_row       (req_cell_row),
      .req_cell_value     (req_cell_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_inflated_value (rsp_inflated_value),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   inflation_checker u_inflation_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_cell_col       (req_cell_col),
      .req_cell_row       (req_cell_row),
      .req_cell_value     (req_cell_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_inflated_value (rsp_inflated_value),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .mismatches         (checker_errors),
      .answers_pending    (results_pending),
      .answers_checked    (results_compared)
   );

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, results_pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int cols_in_use();
      return (shadow_width > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(shadow_width);
   endfunction

   function automatic int rows_in_use();
      return (shadow_height > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(shadow_height);
   endfunction

   function automatic int reach_in_use();
      return (shadow_margin > DEF_MAX_MARGIN) ? DEF_MAX_MARGIN : int'(shadow_margin);
   endfunction

   function automatic bit on_map(int col, int row);
      return (col < cols_in_use()) && (row < rows_in_use());
   endfunction

   // Mostly back to back, some short gaps and a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_value(bit obstacle);
      int v;
      if (obstacle) return int'(OBSTACLE_VALUE);
      v = $urandom_range(0, 255);
      return (v == int'(OBSTACLE_VALUE)) ? v + 1 : v;
   endfunction

   // Coordinates cluster near both map edges so windows overlap and get reused.
   function automatic int zone_coord(int extent);
      if (extent == 0) return $urandom_range(0, COORD_MAX);
      if (extent <= 2 * ZONE_SPAN) return $urandom_range(0, extent - 1);
      if ($urandom_range(0, 1) == 1) return $urandom_range(0, ZONE_SPAN - 1);
      return $urandom_range(extent - ZONE_SPAN, extent - 1);
   endfunction

   // Present one request transaction and hold it until the core takes it.
   task automatic send_item(opcode_type op, int col, int row, int value);
      int gap;
      start          <= 1'b1;
      req_opcode     <= op;
      req_cell_col   <= CELL_COL_W'(col);
      req_cell_row   <= CELL_ROW_W'(row);
      req_cell_value <= CELL_VALUE_W'(value);
      do @(posedge clock); while (busy);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start          <= 1'b0;
         req_opcode     <= OPCODE_W'($urandom_range(0, 1));
         req_cell_col   <= CELL_COL_W'($urandom);
         req_cell_row   <= CELL_ROW_W'($urandom);
         req_cell_value <= CELL_VALUE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_cell(int col, int row, int value);
      send_item(OP_WRITE, col, row, value);
      if (on_map(col, row)) cell_written[row * DEF_MAX_COLS + col] = 1'b1;
   endtask

   // A query only goes out once every cell of its clipped window holds a value.
   task automatic query_cell(int col, int row);
      int reach;
      int c_lo;
      int c_hi;
      int r_lo;
      int r_hi;
      int r;
      int c;
      if (on_map(col, row)) begin
         reach = reach_in_use();
         c_lo  = (col >= reach) ? col - reach : 0;
         r_lo  = (row >= reach) ? row - reach : 0;
         c_hi  = (col + reach > cols_in_use() - 1) ? cols_in_use() - 1 : col + reach;
         r_hi  = (row + reach > rows_in_use() - 1) ? rows_in_use() - 1 : row + reach;
         for (r = r_lo; r <= r_hi; r++) begin
            for (c = c_lo; c <= c_hi; c++) begin
               if (!cell_written[r * DEF_MAX_COLS + c]) begin
                  write_cell(c, r, pick_value(1'b0));
                  fill_writes++;
               end
            end
         end
         inside_queries++;
      end else begin
         outside_queries++;
      end
      send_item(OP_QUERY, col, row, $urandom_range(0, 255));
   endtask

   // Stop sending until every predicted result has come back and the core is quiet.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transaction: setup cycle, then access until pready.
   task automatic csr_access(bit is_write, int idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_W'(idx * 4);
      pwdata  <= is_write ? CSR_DATA_W'(value) : CSR_DATA_W'($urandom);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (is_write) begin
         case (idx)
            REG_MAP_WIDTH:  shadow_width  = value[DIM_W-1:0];
            REG_MAP_HEIGHT: shadow_height = value[DIM_W-1:0];
            REG_MARGIN:     shadow_margin = value[MARGIN_W-1:0];
            default: ;
         endcase
      end
   endtask

   // One register setting followed by a mix of random transactions.
   task automatic run_phase(int width_val, int height_val, int margin_val);
      int stop_at;
      int pick;
      int area;
      wait_idle();
      csr_access(1'b1, REG_MAP_WIDTH, width_val);
      csr_access(1'b1, REG_MAP_HEIGHT, height_val);
      csr_access(1'b1, REG_MARGIN, margin_val);
      csr_access(1'b0, $urandom_range(REG_MAP_WIDTH, REG_MARGIN), 0);
      settings_used++;
      burst_mode = ($urandom_range(0, 3) == 0);
      area       = (2 * reach_in_use() + 1) * (2 * reach_in_use() + 1);
      stop_at    = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
         if (pick < 45) begin
            query_cell(zone_coord(cols_in_use()), zone_coord(rows_in_use()));
         end else if (pick < 80) begin
            write_cell(zone_coord(cols_in_use()), zone_coord(rows_in_use()),
                       pick_value($urandom_range(0, area) == 0));
         end else if (pick < 90) begin
            write_cell($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                       pick_value($urandom_range(0, 3) == 0));
         end else if (pick < 98) begin
            query_cell($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         end else begin
            wait_idle();
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = '0;
      req_cell_col   = '0;
      req_cell_row   = '0;
      req_cell_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register values after reset.
      csr_access(1'b0, REG_MAP_WIDTH, 0);
      csr_access(1'b0, REG_MAP_HEIGHT, 0);
      csr_access(1'b0, REG_MARGIN, 0);

      // Corner window with extreme values, then an obstacle at the window corner.
      csr_access(1'b1, REG_MARGIN, 1);
      write_cell(0, 0, -128);
      write_cell(1, 0, 127);
      write_cell(0, 1, 0);
      write_cell(1, 1, -1);
      query_cell(0, 0);
      write_cell(1, 1, int'(OBSTACLE_VALUE));
      query_cell(0, 0);
      // Obstacle exactly at the margin, then one cell beyond it.
      query_cell(2, 2);
      query_cell(3, 3);
      // Far corner of the full map, clipped on the high side.
      write_cell(COORD_MAX, COORD_MAX, 127);
      query_cell(COORD_MAX, COORD_MAX);
      write_cell(COORD_MAX - 1, 0, int'(OBSTACLE_VALUE));
      query_cell(COORD_MAX, 1);

      // Zero margin sees only the cell itself; the widest margin sees far.
      wait_idle();
      csr_access(1'b1, REG_MARGIN, 0);
      query_cell(1, 1);
      query_cell(0, 0);
      wait_idle();
      csr_access(1'b1, REG_MARGIN, DEF_MAX_MARGIN);
      query_cell(0, 0);

      // Narrow map: off-map query, ignored write, last column.
      wait_idle();
      csr_access(1'b1, REG_MARGIN, 2);
      csr_access(1'b1, REG_MAP_WIDTH, 300);
      query_cell(300, 5);
      write_cell(400, 5, int'(OBSTACLE_VALUE));
      query_cell(299, 300);

      // Zero width: nothing is on the map.
      wait_idle();
      csr_access(1'b1, REG_MAP_WIDTH, 0);
      query_cell(0, 0);
      write_cell(0, 0, int'(OBSTACLE_VALUE));

      // Oversized width saturates; single-row map.
      wait_idle();
      csr_access(1'b1, REG_MAP_WIDTH, (1 << DIM_W) - 1);
      csr_access(1'b0, REG_MAP_WIDTH, 0);
      csr_access(1'b1, REG_MAP_HEIGHT, 1);
      query_cell(COORD_MAX, 0);
      query_cell(0, 1);

      // A write to an unmapped register must change nothing.
      wait_idle();
      csr_access(1'b1, REG_UNMAPPED, 5);
      csr_access(1'b1, REG_MAP_HEIGHT, DEF_MAX_ROWS);
      query_cell(COORD_MAX, 2);

      // Random traffic under a series of register settings.
      run_phase(DEF_MAX_COLS, DEF_MAX_ROWS, 3);
      run_phase(16, 16, 2);
      run_phase(1, 1, 0);
      run_phase((1 << DIM_W) - 1, 7, 1);
      run_phase(9, (1 << DIM_W) - 1, 6);
      run_phase(0, 40, 2);
      run_phase(33, 20, 4);
      run_phase($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, DEF_MAX_MARGIN));
      run_phase((1 << DIM_W) - 1, (1 << DIM_W) - 1, 1);

      wait_idle();
      $display("Sent %0d requests (%0d of them window fills) under %0d register settings.",
               items_sent, fill_writes, settings_used + 1);
      $display("Queries on the map: %0d, off the map: %0d; results compared: %0d.",
               inside_queries, outside_queries, results_compared);
      if (checker_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
